[src/rgag_pkg.sv]
// rgag_pkg: shared types, widths and register codes of the radial glow alpha generator
// no dependencies
`default_nettype none
package rgag_pkg;

  localparam int MAX_SIZE_DEF        = 1024;
  localparam int ALPHA_FRAC_BITS_DEF = 16;

  localparam int COORD_W        = 10;
  localparam int RADIUS_W       = 11;
  localparam int LEVEL_W        = 16;
  localparam int DIST_FRAC_BITS = 16;
  localparam int OFFSET_W       = 11;
  localparam int SQUARE_W       = 2 * OFFSET_W;
  localparam int SUM_W          = 24;
  localparam int ROOT_W         = SUM_W / 2 + DIST_FRAC_BITS;
  localparam int NUM_W          = RADIUS_W + DIST_FRAC_BITS + 1;
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 32;

  typedef enum logic [2:0] {
    REG_IMAGE_SIZE   = 3'd0,
    REG_CORE_RAD     = 3'd1,
    REG_EDGE_RAD     = 3'd2,
    REG_RED_LEVEL    = 3'd3,
    REG_GREEN_LEVEL  = 3'd4,
    REG_BLUE_LEVEL   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                vld;
    logic                full;
    logic                zero;
  } ctl_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] image_size;
    logic [RADIUS_W-1:0] core_rad;
    logic [RADIUS_W-1:0] edge_rad;
    logic [LEVEL_W-1:0]  red_level;
    logic [LEVEL_W-1:0]  green_level;
    logic [LEVEL_W-1:0]  blue_level;
  } cfg_t;

endpackage
`default_nettype wire

[src/radial_glow_alpha_generator.sv]
// radial_glow_alpha_generator: glow sprite pixel colour and alpha, fully pipelined
// depends on rgag_pkg, rgag_regs, rgag_sqrt_cell, rgag_div_cell
//
// usage
//   input: a pixel beat (in_pixel_col, in_pixel_row) is taken at a clock edge with
//   start high and busy low. busy is high only during reset, so one beat per cycle.
//   output: each result shows for one cycle with out_valid high; results come in
//   input order. the receiver cannot stall, and the block needs no backpressure.
//   pipeline: the offset, square and sum registers, then the row of square root
//   cells (one root bit each), the numerator register, the row of divider cells
//   (one quotient bit each), and the product and output registers. throughput:
//   one pixel per clock.
//   configuration: apb, registers at byte address 4*index; the user must write them only
//   while idle, the block does not enforce it. reset: synchronous, clears the pipeline
//   valid bits and loads the register defaults (size 256, radii 32 and 128, white colour), no clearing pass.
`default_nettype none
module radial_glow_alpha_generator import rgag_pkg::*; #(
  parameter int MAX_SIZE        = MAX_SIZE_DEF,
  parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [COORD_W-1:0]       in_pixel_col,
  input  wire logic [COORD_W-1:0]       in_pixel_row,
  output logic                          out_valid,
  output logic      [LEVEL_W-1:0]       out_red,
  output logic      [LEVEL_W-1:0]       out_green,
  output logic      [LEVEL_W-1:0]       out_blue,
  output logic      [ALPHA_FRAC_BITS:0] out_alpha,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [PDATA_W-1:0]       pwdata,
  output logic      [PDATA_W-1:0]       prdata,
  output logic                          pready
);

  localparam int A      = ALPHA_FRAC_BITS;
  localparam int PROD_W = 2 * A + 2;

  cfg_t cfg;

  rgag_regs #(.MAX_SIZE(MAX_SIZE)) u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign busy = ~rst_n;

  // radius thresholds and divisor from the registers
  logic [SUM_W-1:0] in2_r, out2_r;
  logic [NUM_W-1:0] den;
  logic [NUM_W-1:0] outer_fx;

  always_ff @(posedge clk) begin
    in2_r  <= (SUM_W'(cfg.core_rad) * SUM_W'(cfg.core_rad)) << 2;
    out2_r <= (SUM_W'(cfg.edge_rad) * SUM_W'(cfg.edge_rad)) << 2;
  end

  assign den      = {RADIUS_W'(cfg.edge_rad - cfg.core_rad),
                     (DIST_FRAC_BITS + 1)'(0)};
  assign outer_fx = {cfg.edge_rad, (DIST_FRAC_BITS + 1)'(0)};

  // front stages: capture, offsets, squares, sum and compare
  logic                  v0_r, v1_r, v2_r;
  logic [COORD_W-1:0]    col_r, row_r;
  logic [OFFSET_W-1:0]   ax_r, ay_r;
  logic [SQUARE_W-1:0]   sx_r, sy_r;
  logic signed [RADIUS_W+1:0] dx, dy;
  logic [SUM_W-1:0]      sum_nxt;
  ctl_t                  c3_r;
  logic [SUM_W-1:0]      sum_r;

  always_comb begin
    dx      = $signed({1'b0, col_r, 1'b0}) - $signed({2'b00, cfg.image_size});
    dy      = $signed({1'b0, row_r, 1'b0}) - $signed({2'b00, cfg.image_size});
    sum_nxt = SUM_W'(sx_r) + SUM_W'(sy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      c3_r <= '0;
    end else begin
      v0_r      <= start & ~busy;
      v1_r      <= v0_r;
      v2_r      <= v1_r;
      c3_r.vld  <= v2_r;
      c3_r.full <= (sum_nxt <= in2_r);
      c3_r.zero <= (sum_nxt >= out2_r);
    end
  end

  always_ff @(posedge clk) begin
    col_r <= in_pixel_col;
    row_r <= in_pixel_row;
    ax_r  <= dx[RADIUS_W+1] ? OFFSET_W'(-dx) : OFFSET_W'(dx);
    ay_r  <= dy[RADIUS_W+1] ? OFFSET_W'(-dy) : OFFSET_W'(dy);
    sx_r  <= ax_r * ax_r;
    sy_r  <= ay_r * ay_r;
    sum_r <= sum_nxt;
  end

  // square root row
  ctl_t              sq_ctl  [ROOT_W+1];
  logic [SUM_W-1:0]  sq_sum  [ROOT_W+1];
  logic [ROOT_W+1:0] sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];

  assign sq_ctl[0]  = c3_r;
  assign sq_sum[0]  = sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  genvar g;
  generate
    for (g = 0; g < ROOT_W; g++) begin : g_sqrt
      rgag_sqrt_cell #(.PAIR(ROOT_W - 1 - g)) u_cell (
        .clk, .rst_n,
        .ctl_i(sq_ctl[g]), .sum_i(sq_sum[g]), .rem_i(sq_rem[g]), .root_i(sq_root[g]),
        .ctl_o(sq_ctl[g+1]), .sum_o(sq_sum[g+1]), .rem_o(sq_rem[g+1]),
        .root_o(sq_root[g+1])
      );
    end
  endgenerate

  // numerator stage
  ctl_t             cn_r;
  logic [NUM_W-1:0] num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cn_r <= '0;
    end else begin
      cn_r <= sq_ctl[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    num_r <= outer_fx - NUM_W'(sq_root[ROOT_W]);
  end

  // divider row
  ctl_t             dv_ctl [A+2];
  logic [NUM_W-1:0] dv_rem [A+2];
  logic [A:0]       dv_quo [A+2];

  assign dv_ctl[0] = cn_r;
  assign dv_rem[0] = num_r;
  assign dv_quo[0] = '0;

  generate
    for (g = 0; g <= A; g++) begin : g_div
      rgag_div_cell #(.ALPHA_FRAC_BITS(A), .FIRST(g == 0)) u_cell (
        .clk, .rst_n,
        .ctl_i(dv_ctl[g]), .den_i(den), .rem_i(dv_rem[g]), .quo_i(dv_quo[g]),
        .ctl_o(dv_ctl[g+1]), .rem_o(dv_rem[g+1]), .quo_o(dv_quo[g+1])
      );
    end
  endgenerate

  // square of the ratio, then rounding and output
  ctl_t              cp_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] rounded;
  logic [A:0]        alpha_nxt;
  logic              out_vld_r;
  logic [A:0]        out_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r <= '0;
    end else begin
      cp_r <= dv_ctl[A+1];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(dv_quo[A+1]) * PROD_W'(dv_quo[A+1]);
  end

  always_comb begin
    rounded = (prod_r + (PROD_W'(1) << (A - 1))) >> A;
    if (cp_r.full) begin
      alpha_nxt = (A+1)'(1) << A;
    end else if (cp_r.zero) begin
      alpha_nxt = '0;
    end else begin
      alpha_nxt = rounded[A:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cp_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_alpha_r <= alpha_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_alpha = out_alpha_r;
  assign out_red   = cfg.red_level;
  assign out_green = cfg.green_level;
  assign out_blue  = cfg.blue_level;

endmodule
`default_nettype wire

[src/rgag_regs.sv]
// rgag_regs: apb register file holding sprite size, radii and colour
// depends on rgag_pkg
`default_nettype none
module rgag_regs import rgag_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;
  logic [RADIUS_W-1:0] size_wr;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    size_wr = pwdata[RADIUS_W-1:0];
    if (int'(pwdata[RADIUS_W-1:0]) > MAX_SIZE) begin
      size_wr = RADIUS_W'(MAX_SIZE);
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[PADDR_W-1:2])
        REG_IMAGE_SIZE:   cfg_nxt.image_size   = size_wr;
        REG_CORE_RAD:     cfg_nxt.core_rad     = pwdata[RADIUS_W-1:0];
        REG_EDGE_RAD:     cfg_nxt.edge_rad     = pwdata[RADIUS_W-1:0];
        REG_RED_LEVEL:    cfg_nxt.red_level    = pwdata[LEVEL_W-1:0];
        REG_GREEN_LEVEL:  cfg_nxt.green_level  = pwdata[LEVEL_W-1:0];
        REG_BLUE_LEVEL:   cfg_nxt.blue_level   = pwdata[LEVEL_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_size   <= RADIUS_W'(256);
      cfg_r.core_rad     <= RADIUS_W'(32);
      cfg_r.edge_rad     <= RADIUS_W'(128);
      cfg_r.red_level    <= '1;
      cfg_r.green_level  <= '1;
      cfg_r.blue_level   <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_IMAGE_SIZE:   prdata = PDATA_W'(cfg_r.image_size);
      REG_CORE_RAD:     prdata = PDATA_W'(cfg_r.core_rad);
      REG_EDGE_RAD:     prdata = PDATA_W'(cfg_r.edge_rad);
      REG_RED_LEVEL:    prdata = PDATA_W'(cfg_r.red_level);
      REG_GREEN_LEVEL:  prdata = PDATA_W'(cfg_r.green_level);
      REG_BLUE_LEVEL:   prdata = PDATA_W'(cfg_r.blue_level);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[src/rgag_sqrt_cell.sv]
// rgag_sqrt_cell: one root bit of the pipelined square root of the squared distance
// depends on rgag_pkg
`default_nettype none
module rgag_sqrt_cell import rgag_pkg::*; #(
  parameter int PAIR = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctl_t              ctl_i,
  input  wire logic [SUM_W-1:0]  sum_i,
  input  wire logic [ROOT_W+1:0] rem_i,
  input  wire logic [ROOT_W-1:0] root_i,
  output ctl_t                   ctl_o,
  output logic      [SUM_W-1:0]  sum_o,
  output logic      [ROOT_W+1:0] rem_o,
  output logic      [ROOT_W-1:0] root_o
);

  logic [1:0]        pair_bits;
  logic [ROOT_W+1:0] rem_sh, trial, rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic              ge;
  ctl_t              ctl_r;
  logic [SUM_W-1:0]  sum_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;

  // radicand is the sum shifted up by twice the fraction bits
  generate
    if (PAIR >= DIST_FRAC_BITS) begin : g_hi
      assign pair_bits = sum_i[2*(PAIR-DIST_FRAC_BITS)+1 -: 2];
    end else begin : g_lo
      assign pair_bits = 2'b00;
    end
  endgenerate

  always_comb begin
    rem_sh   = {rem_i[ROOT_W-1:0], pair_bits};
    trial    = {root_i, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_i;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign ctl_o  = ctl_r;
  assign sum_o  = sum_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

[src/rgag_div_cell.sv]
// rgag_div_cell: one quotient bit of the pipelined falloff ratio divider
// depends on rgag_pkg
`default_nettype none
module rgag_div_cell import rgag_pkg::*; #(
  parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF,
  parameter bit FIRST           = 1'b0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ctl_t                     ctl_i,
  input  wire logic [NUM_W-1:0]         den_i,
  input  wire logic [NUM_W-1:0]         rem_i,
  input  wire logic [ALPHA_FRAC_BITS:0] quo_i,
  output ctl_t                          ctl_o,
  output logic      [NUM_W-1:0]         rem_o,
  output logic      [ALPHA_FRAC_BITS:0] quo_o
);

  logic [NUM_W:0]           rem_sh, rem_nxt;
  logic                     ge;
  ctl_t                     ctl_r;
  logic [NUM_W-1:0]         rem_r;
  logic [ALPHA_FRAC_BITS:0] quo_r;

  always_comb begin
    rem_sh  = FIRST ? {1'b0, rem_i} : {rem_i, 1'b0};
    ge      = (rem_sh >= {1'b0, den_i});
    rem_nxt = ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt[NUM_W-1:0];
    quo_r <= {quo_i[ALPHA_FRAC_BITS-1:0], ge};
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule
`default_nettype wire

[src/rgag_checker.sv]
// rgag_assert: port-level checks of the glow generator, bound to the top level
// depends on rgag_pkg and radial_glow_alpha_generator
`default_nettype none
module rgag_assert import rgag_pkg::*; #(
  parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     out_valid,
  input wire logic [ALPHA_FRAC_BITS:0] out_alpha
);

  localparam int LAT = ROOT_W + ALPHA_FRAC_BITS + 8;

  // every accepted beat gives a result after the pipeline latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted beat");

  // no result without a beat accepted the same latency earlier
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted beat");

  // alpha never exceeds fully opaque
  a_alpha_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha <= ((ALPHA_FRAC_BITS+1)'(1) << ALPHA_FRAC_BITS)))
    else $error("alpha above one");

endmodule

bind radial_glow_alpha_generator rgag_assert #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_alpha(out_alpha)
);
`default_nettype wire
